// ----- sv/parp_pkg.sv -----
package parp_pkg;

    // Field widths
    localparam int COORD_WIDTH     = 24;
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_WIDTH     = 18;
    localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
    localparam int ANGLE_WORK_WIDTH = ANGLE_WIDTH + 2;
    localparam int ANGLE_Z_WIDTH   = 26;
    localparam int TRIG_FRAC       = 28;
    localparam int TRIG_WIDTH      = TRIG_FRAC + 4;
    localparam int PROD_WIDTH      = DIFF_WIDTH + TRIG_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 1;
    localparam int FIN_WIDTH       = SUM_WIDTH - TRIG_FRAC + 1;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH;

    // Pipeline depth from accepting edge to result register
    localparam int LATENCY = CORDIC_STAGES + 6;

    // Axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_SELECT  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_DEGREES = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_X      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Y      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Z      = 3'd4;

    // Angles in degrees with 8 fractional bits
    localparam int DEG_HALF_INT = 180;
    localparam logic signed [ANGLE_WORK_WIDTH-1:0] DEG_HALF =
        ANGLE_WORK_WIDTH'(DEG_HALF_INT * 256);
    localparam logic signed [ANGLE_WORK_WIDTH-1:0] DEG_QUARTER =
        ANGLE_WORK_WIDTH'(DEG_HALF_INT * 128);
    localparam logic signed [ANGLE_WORK_WIDTH-1:0] DEG_FULL =
        ANGLE_WORK_WIDTH'(DEG_HALF_INT * 512);

    // CORDIC start value, 1/gain with 28 fractional bits
    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = TRIG_WIDTH'(163008219);

    typedef struct packed {
        logic [1:0]                    axis;
        logic signed [COORD_WIDTH-1:0] xi;
        logic signed [COORD_WIDTH-1:0] yi;
        logic signed [COORD_WIDTH-1:0] zi;
        logic signed [DIFF_WIDTH-1:0]  u;
        logic signed [DIFF_WIDTH-1:0]  v;
    } item_t;

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0]    x;
        logic signed [TRIG_WIDTH-1:0]    y;
        logic signed [ANGLE_Z_WIDTH-1:0] z;
        logic                            flip;
    } rot_t;

    // atan(2^-i) in degrees with 16 fractional bits
    function automatic logic signed [ANGLE_Z_WIDTH-1:0] atan_deg(input int i);
        logic signed [ANGLE_Z_WIDTH-1:0] r;
        begin
            case (i)
                0:  r = ANGLE_Z_WIDTH'(2949120);
                1:  r = ANGLE_Z_WIDTH'(1740967);
                2:  r = ANGLE_Z_WIDTH'(919879);
                3:  r = ANGLE_Z_WIDTH'(466945);
                4:  r = ANGLE_Z_WIDTH'(234379);
                5:  r = ANGLE_Z_WIDTH'(117304);
                6:  r = ANGLE_Z_WIDTH'(58666);
                7:  r = ANGLE_Z_WIDTH'(29335);
                8:  r = ANGLE_Z_WIDTH'(14668);
                9:  r = ANGLE_Z_WIDTH'(7334);
                10: r = ANGLE_Z_WIDTH'(3667);
                11: r = ANGLE_Z_WIDTH'(1833);
                12: r = ANGLE_Z_WIDTH'(917);
                13: r = ANGLE_Z_WIDTH'(458);
                14: r = ANGLE_Z_WIDTH'(229);
                15: r = ANGLE_Z_WIDTH'(115);
                16: r = ANGLE_Z_WIDTH'(57);
                17: r = ANGLE_Z_WIDTH'(29);
                18: r = ANGLE_Z_WIDTH'(14);
                19: r = ANGLE_Z_WIDTH'(7);
                20: r = ANGLE_Z_WIDTH'(4);
                21: r = ANGLE_Z_WIDTH'(2);
                22: r = ANGLE_Z_WIDTH'(1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- sv/parp_front.sv -----
module parp_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]   x_in,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]   y_in,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]   z_in,
    input  logic [1:0]                                axis_select,
    input  logic signed [parp_pkg::ANGLE_WIDTH-1:0]   angle_degrees,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]   pivot_x,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]   pivot_y,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]   pivot_z,
    output logic                                      valid_out,
    output parp_pkg::item_t                           item_out,
    output parp_pkg::rot_t                            rot_out
);
    import parp_pkg::*;

    logic                                  valid1_reg, valid1_next;
    item_t                                 item1_reg, item1_next;
    logic signed [ANGLE_WORK_WIDTH-1:0]    ang1_reg, ang1_next;
    logic signed [ANGLE_WORK_WIDTH-1:0]    ang_ext;
    logic signed [ANGLE_WORK_WIDTH-1:0]    ang_sel;
    logic signed [DIFF_WIDTH-1:0]          dx, dy, dz;

    logic                                  valid2_reg, valid2_next;
    item_t                                 item2_reg, item2_next;
    rot_t                                  rot2_reg, rot2_next;
    logic signed [ANGLE_WORK_WIDTH-1:0]    quad;

    // Take point relative to pivot and pick the rotated pair
    always_comb
    begin
        dx = DIFF_WIDTH'(x_in) - DIFF_WIDTH'(pivot_x);
        dy = DIFF_WIDTH'(y_in) - DIFF_WIDTH'(pivot_y);
        dz = DIFF_WIDTH'(z_in) - DIFF_WIDTH'(pivot_z);
        valid1_next    = start;
        item1_next.axis = axis_select;
        item1_next.xi  = x_in;
        item1_next.yi  = y_in;
        item1_next.zi  = z_in;
        case (axis_select)
            AXIS_X:
            begin
                item1_next.u = dy;
                item1_next.v = dz;
            end
            AXIS_Y:
            begin
                item1_next.u = dz;
                item1_next.v = dx;
            end
            default:
            begin
                item1_next.u = dx;
                item1_next.v = dy;
            end
        endcase
    end

    // Negate for the y axis and wrap into one turn about zero
    always_comb
    begin
        ang_ext = ANGLE_WORK_WIDTH'(angle_degrees);
        ang_sel = (axis_select == AXIS_Y) ? -ang_ext : ang_ext;
        if (ang_sel > DEG_HALF)
            ang1_next = ang_sel - DEG_FULL;
        else if (ang_sel <= -DEG_HALF)
            ang1_next = ang_sel + DEG_FULL;
        else
            ang1_next = ang_sel;
    end

    // Fold into the right half plane and seed the CORDIC vector
    always_comb
    begin
        valid2_next = valid1_reg;
        item2_next  = item1_reg;
        if (ang1_reg > DEG_QUARTER)
        begin
            quad           = ang1_reg - DEG_HALF;
            rot2_next.flip = 1'b1;
        end
        else if (ang1_reg < -DEG_QUARTER)
        begin
            quad           = ang1_reg + DEG_HALF;
            rot2_next.flip = 1'b1;
        end
        else
        begin
            quad           = ang1_reg;
            rot2_next.flip = 1'b0;
        end
        rot2_next.x = CORDIC_GAIN;
        rot2_next.y = '0;
        rot2_next.z = ANGLE_Z_WIDTH'(quad) <<< 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= item1_next;
        ang1_reg  <= ang1_next;
        item2_reg <= item2_next;
        rot2_reg  <= rot2_next;
    end

    assign valid_out = valid2_reg;
    assign item_out  = item2_reg;
    assign rot_out   = rot2_reg;

endmodule

// ----- sv/parp_cordic.sv -----
module parp_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  parp_pkg::item_t item_in,
    input  parp_pkg::rot_t  rot_in,
    output logic            valid_out,
    output parp_pkg::item_t item_out,
    output parp_pkg::rot_t  rot_out
);
    import parp_pkg::*;

    logic  valid_reg [0:CORDIC_STAGES-1];
    item_t item_reg  [0:CORDIC_STAGES-1];
    rot_t  rot_reg   [0:CORDIC_STAGES-1];

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic                         valid_src;
        item_t                        item_src;
        rot_t                         rot_src;
        rot_t                         rot_next;
        logic signed [TRIG_WIDTH-1:0] xs, ys;

        if (i == 0)
        begin : g_first
            assign valid_src = valid_in;
            assign item_src  = item_in;
            assign rot_src   = rot_in;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[i-1];
            assign item_src  = item_reg[i-1];
            assign rot_src   = rot_reg[i-1];
        end

        // Steer towards zero residual angle
        always_comb
        begin
            xs = rot_src.x >>> i;
            ys = rot_src.y >>> i;
            rot_next.flip = rot_src.flip;
            if (!rot_src.z[ANGLE_Z_WIDTH-1])
            begin
                rot_next.x = rot_src.x - ys;
                rot_next.y = rot_src.y + xs;
                rot_next.z = rot_src.z - atan_deg(i);
            end
            else
            begin
                rot_next.x = rot_src.x + ys;
                rot_next.y = rot_src.y - xs;
                rot_next.z = rot_src.z + atan_deg(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            item_reg[i] <= item_src;
            rot_reg[i]  <= rot_next;
        end
    end

    assign valid_out = valid_reg[CORDIC_STAGES-1];
    assign item_out  = item_reg[CORDIC_STAGES-1];
    assign rot_out   = rot_reg[CORDIC_STAGES-1];

endmodule

// ----- sv/parp_rotate.sv -----
module parp_rotate (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    valid_in,
    input  parp_pkg::item_t                         item_in,
    input  parp_pkg::rot_t                          rot_in,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0] pivot_x,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0] pivot_y,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0] pivot_z,
    output logic                                    done,
    output logic signed [parp_pkg::COORD_WIDTH-1:0] x_out,
    output logic signed [parp_pkg::COORD_WIDTH-1:0] y_out,
    output logic signed [parp_pkg::COORD_WIDTH-1:0] z_out,
    output logic                                    saturated
);
    import parp_pkg::*;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] value;
        logic                          sat;
    } fin_t;

    localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1) <<< (TRIG_FRAC - 1);
    localparam logic signed [FIN_WIDTH-1:0] COORD_HI =
        (FIN_WIDTH'(1) <<< (COORD_WIDTH - 1)) - FIN_WIDTH'(1);
    localparam logic signed [FIN_WIDTH-1:0] COORD_LO = -(FIN_WIDTH'(1) <<< (COORD_WIDTH - 1));

    // Round, add pivot back and clamp
    function automatic fin_t finish_coord(input logic signed [SUM_WIDTH-1:0] sum,
                                          input logic signed [COORD_WIDTH-1:0] pivot);
        logic signed [SUM_WIDTH-1:0] biased;
        logic signed [FIN_WIDTH-1:0] val;
        fin_t                        r;
        begin
            biased = sum + ROUND_HALF;
            val    = FIN_WIDTH'(signed'(biased[SUM_WIDTH-1:TRIG_FRAC])) + FIN_WIDTH'(pivot);
            if (val > COORD_HI)
            begin
                r.value = COORD_HI[COORD_WIDTH-1:0];
                r.sat   = 1'b1;
            end
            else if (val < COORD_LO)
            begin
                r.value = COORD_LO[COORD_WIDTH-1:0];
                r.sat   = 1'b1;
            end
            else
            begin
                r.value = val[COORD_WIDTH-1:0];
                r.sat   = 1'b0;
            end
            return r;
        end
    endfunction

    logic                          vf_reg, vm_reg, vs_reg;
    item_t                         itf_reg, itm_reg, its_reg;
    logic signed [TRIG_WIDTH-1:0]  cos_reg, cos_next, sin_reg, sin_next;
    logic signed [PROD_WIDTH-1:0]  uc_reg, us_reg, vc_reg, vs_prod_reg;
    logic signed [SUM_WIDTH-1:0]   suma_reg, suma_next, sumb_reg, sumb_next;

    logic                          done_reg;
    logic signed [COORD_WIDTH-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic                          sat_reg, sat_next;
    logic signed [COORD_WIDTH-1:0] piv_a, piv_b;
    fin_t                          fa, fb;

    // Undo the half-turn fold
    always_comb
    begin
        cos_next = rot_in.flip ? -rot_in.x : rot_in.x;
        sin_next = rot_in.flip ? -rot_in.y : rot_in.y;
    end

    // Form the two rotated sums
    always_comb
    begin
        suma_next = SUM_WIDTH'(uc_reg) - SUM_WIDTH'(vs_prod_reg);
        sumb_next = SUM_WIDTH'(us_reg) + SUM_WIDTH'(vc_reg);
    end

    // Finish both coordinates and place them by axis
    always_comb
    begin
        case (its_reg.axis)
            AXIS_X:
            begin
                piv_a = pivot_y;
                piv_b = pivot_z;
            end
            AXIS_Y:
            begin
                piv_a = pivot_z;
                piv_b = pivot_x;
            end
            default:
            begin
                piv_a = pivot_x;
                piv_b = pivot_y;
            end
        endcase
        fa = finish_coord(suma_reg, piv_a);
        fb = finish_coord(sumb_reg, piv_b);
        x_next   = its_reg.xi;
        y_next   = its_reg.yi;
        z_next   = its_reg.zi;
        sat_next = fa.sat | fb.sat;
        case (its_reg.axis)
            AXIS_X:
            begin
                y_next = fa.value;
                z_next = fb.value;
            end
            AXIS_Y:
            begin
                z_next = fa.value;
                x_next = fb.value;
            end
            AXIS_Z:
            begin
                x_next = fa.value;
                y_next = fb.value;
            end
            default:
                sat_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            vs_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vf_reg   <= valid_in;
            vm_reg   <= vf_reg;
            vs_reg   <= vm_reg;
            done_reg <= vs_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        itf_reg     <= item_in;
        cos_reg     <= cos_next;
        sin_reg     <= sin_next;
        itm_reg     <= itf_reg;
        uc_reg      <= itf_reg.u * cos_reg;
        us_reg      <= itf_reg.u * sin_reg;
        vc_reg      <= itf_reg.v * cos_reg;
        vs_prod_reg <= itf_reg.v * sin_reg;
        its_reg     <= itm_reg;
        suma_reg    <= suma_next;
        sumb_reg    <= sumb_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        sat_reg     <= sat_next;
    end

    assign done      = done_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign saturated = sat_reg;

endmodule

// ----- sv/point_axis_rotation_about_pivot_unit.sv -----
// Rotates one 3D point per beat about a pivot, around the x, y or z axis.
//
// Input: a beat is taken at each rising edge with start high and busy low.
// busy is always low, so a new point may enter in every cycle.
// Output: each result is shown on x_out, y_out, z_out and saturated for
// exactly one cycle, marked by done. The receiver cannot hold results off.
// Pipeline: CORDIC_STAGES + 6 register stages, the first loaded at the
// accepting edge: two angle-preparation stages, one stage per CORDIC
// iteration, then sign fold, multiply, sum and round/clamp stages. done
// is registered together with the result.
// Throughput: one point per cycle, set by the fully pipelined CORDIC.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (0 axis, 1 angle, 2..4 pivot x/y/z). Write only while no point is in
// flight; sine and cosine are recomputed for every point from the registers.
// Axis code 3 passes the point through unchanged with saturated low.
// Reset: rst_n clears all valid bits and sets axis to z, angle and pivot
// to zero; points in flight are dropped.
module point_axis_rotation_about_pivot_unit (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]     x_in,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]     y_in,
    input  logic signed [parp_pkg::COORD_WIDTH-1:0]     z_in,
    output logic                                        done,
    output logic signed [parp_pkg::COORD_WIDTH-1:0]     x_out,
    output logic signed [parp_pkg::COORD_WIDTH-1:0]     y_out,
    output logic signed [parp_pkg::COORD_WIDTH-1:0]     z_out,
    output logic                                        saturated,
    input  logic                                        cfg_write,
    input  logic [parp_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [parp_pkg::CFG_DATA_WIDTH-1:0]         cfg_data
);
    import parp_pkg::*;

    logic [1:0]                     axis_select_reg;
    logic signed [ANGLE_WIDTH-1:0]  angle_degrees_reg;
    logic signed [COORD_WIDTH-1:0]  pivot_x_reg, pivot_y_reg, pivot_z_reg;

    logic  front_valid, cordic_valid;
    item_t front_item, cordic_item;
    rot_t  front_rot, cordic_rot;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_select_reg   <= AXIS_Z;
            angle_degrees_reg <= '0;
            pivot_x_reg       <= '0;
            pivot_y_reg       <= '0;
            pivot_z_reg       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AXIS_SELECT:   axis_select_reg   <= cfg_data[1:0];
                REG_ANGLE_DEGREES: angle_degrees_reg <= cfg_data[ANGLE_WIDTH-1:0];
                REG_PIVOT_X:       pivot_x_reg       <= cfg_data[COORD_WIDTH-1:0];
                REG_PIVOT_Y:       pivot_y_reg       <= cfg_data[COORD_WIDTH-1:0];
                REG_PIVOT_Z:       pivot_z_reg       <= cfg_data[COORD_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The pipeline never stalls
    assign busy = 1'b0;

    parp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .x_in          (x_in),
        .y_in          (y_in),
        .z_in          (z_in),
        .axis_select   (axis_select_reg),
        .angle_degrees (angle_degrees_reg),
        .pivot_x       (pivot_x_reg),
        .pivot_y       (pivot_y_reg),
        .pivot_z       (pivot_z_reg),
        .valid_out     (front_valid),
        .item_out      (front_item),
        .rot_out       (front_rot)
    );

    parp_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (front_valid),
        .item_in   (front_item),
        .rot_in    (front_rot),
        .valid_out (cordic_valid),
        .item_out  (cordic_item),
        .rot_out   (cordic_rot)
    );

    parp_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cordic_valid),
        .item_in   (cordic_item),
        .rot_in    (cordic_rot),
        .pivot_x   (pivot_x_reg),
        .pivot_y   (pivot_y_reg),
        .pivot_z   (pivot_z_reg),
        .done      (done),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out),
        .saturated (saturated)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CW = parp_pkg::COORD_WIDTH;

    // Coordinate extremes, Q16.8
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // Angles in degrees with 8 fractional bits
    localparam int QUARTER_TURN = 90 * 256;
    localparam int HALF_TURN    = 180 * 256;
    localparam int FULL_TURN    = 360 * 256;
    localparam logic signed [parp_pkg::ANGLE_WIDTH-1:0] ANGLE_MOST_POS =
        {1'b0, {(parp_pkg::ANGLE_WIDTH-1){1'b1}}};
    localparam logic signed [parp_pkg::ANGLE_WIDTH-1:0] ANGLE_MOST_NEG =
        {1'b1, {(parp_pkg::ANGLE_WIDTH-1){1'b0}}};

    // CORDIC start value, 1/gain with 28 fractional bits
    localparam longint UNIT_GAIN_Q28 = 163008219;
    localparam int     SINCOS_FRAC   = 28;
    localparam int     SINCOS_STEPS  = 16;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 sat;
    } rotated_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] x_in = '0;
    logic signed [CW-1:0] y_in = '0;
    logic signed [CW-1:0] z_in = '0;
    logic done;
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic signed [CW-1:0] z_out;
    logic saturated;
    logic cfg_write = 1'b0;
    logic [parp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [parp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    // Shadow of the block's registers, reset values
    logic [1:0]                               axis_cfg = parp_pkg::AXIS_Z;
    logic signed [parp_pkg::ANGLE_WIDTH-1:0]  angle_cfg = '0;
    logic signed [CW-1:0]                     pivot_x_cfg = '0;
    logic signed [CW-1:0]                     pivot_y_cfg = '0;
    logic signed [CW-1:0]                     pivot_z_cfg = '0;

    // atan(2^-i) in degrees with 16 fractional bits
    longint arctan_q16 [0:SINCOS_STEPS-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    point_t         point_backlog[$];
    rotated_point_t expected_points[$];
    int             beats_taken = 0;
    int             fault_count = 0;

    point_axis_rotation_about_pivot_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .x_in      (x_in),
        .y_in      (y_in),
        .z_in      (z_in),
        .done      (done),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out),
        .saturated (saturated),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Round the product sum, add the pivot back and clamp to the coordinate range
    function automatic logic signed [CW-1:0] settle(input longint acc, input longint pivot,
                                                    inout bit clamped);
        longint v;
        begin
            v = ((acc + (64'sd1 <<< (SINCOS_FRAC - 1))) >>> SINCOS_FRAC) + pivot;
            if (v > longint'(COORD_MAX))
            begin
                clamped = 1'b1;
                return COORD_MAX;
            end
            if (v < longint'(COORD_MIN))
            begin
                clamped = 1'b1;
                return COORD_MIN;
            end
            return CW'(v);
        end
    endfunction

    // Expected rotation of one point under the current register settings
    function automatic rotated_point_t rotate_point(input logic signed [CW-1:0] xi,
                                                    input logic signed [CW-1:0] yi,
                                                    input logic signed [CW-1:0] zi);
        longint px, py, pz, dx, dy, dz, ang, r, cx, cy, za, xs, ys;
        bit flip;
        bit clamped;
        rotated_point_t res;
        begin
            px = pivot_x_cfg;
            py = pivot_y_cfg;
            pz = pivot_z_cfg;
            dx = xi;
            dy = yi;
            dz = zi;
            dx = dx - px;
            dy = dy - py;
            dz = dz - pz;
            ang = angle_cfg;
            if (axis_cfg == parp_pkg::AXIS_Y)
                ang = -ang;

            // Fold the angle into (-180, 180], then into [-90, 90] with a sign flip
            r = (ang + 2 * FULL_TURN) % FULL_TURN;
            flip = 1'b0;
            if (r > HALF_TURN)
                r = r - FULL_TURN;
            if (r > QUARTER_TURN)
            begin
                r = r - HALF_TURN;
                flip = 1'b1;
            end
            else if (r < -QUARTER_TURN)
            begin
                r = r + HALF_TURN;
                flip = 1'b1;
            end

            // Rotation-mode CORDIC for cosine and sine
            cx = UNIT_GAIN_Q28;
            cy = 0;
            za = r * 256;
            for (int i = 0; i < SINCOS_STEPS; i++)
            begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (za >= 0)
                begin
                    cx = cx - ys;
                    cy = cy + xs;
                    za = za - arctan_q16[i];
                end
                else
                begin
                    cx = cx + ys;
                    cy = cy - xs;
                    za = za + arctan_q16[i];
                end
            end
            if (flip)
            begin
                cx = -cx;
                cy = -cy;
            end

            // Rotate the two coordinates across the selected axis
            clamped = 1'b0;
            res.x = xi;
            res.y = yi;
            res.z = zi;
            case (axis_cfg)
                parp_pkg::AXIS_X:
                begin
                    res.y = settle(dy * cx - dz * cy, py, clamped);
                    res.z = settle(dy * cy + dz * cx, pz, clamped);
                end
                parp_pkg::AXIS_Y:
                begin
                    res.x = settle(dx * cx + dz * cy, px, clamped);
                    res.z = settle(dz * cx - dx * cy, pz, clamped);
                end
                parp_pkg::AXIS_Z:
                begin
                    res.x = settle(dx * cx - dy * cy, px, clamped);
                    res.y = settle(dx * cy + dy * cx, py, clamped);
                end
                default:
                begin
                end
            endcase
            res.sat = clamped;
            return res;
        end
    endfunction

    // Random coordinate: full range, near a given value, extremes or small
    function automatic logic signed [CW-1:0] pick_coord(input logic signed [CW-1:0] around);
        begin
            case ($urandom_range(5))
                0, 1, 2: return CW'($urandom);
                3:       return CW'(around + CW'($urandom_range(0, 65535) - 32768));
                4:
                begin
                    case ($urandom_range(3))
                        0:       return COORD_MAX;
                        1:       return COORD_MIN;
                        2:       return '0;
                        default: return '1;
                    endcase
                end
                default: return CW'(int'($urandom_range(0, 4095)) - 2048);
            endcase
        end
    endfunction

    function automatic logic signed [CW-1:0] pick_pivot();
        begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return CW'(int'($urandom_range(0, 131071)) - 65536);
                2:       return CW'($urandom);
                default: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
            endcase
        end
    endfunction

    // Write one register and keep the shadow copy in step
    task automatic set_reg(input logic [parp_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [parp_pkg::CFG_DATA_WIDTH-1:0] val);
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            case (idx)
                parp_pkg::REG_AXIS_SELECT:   axis_cfg    = val[1:0];
                parp_pkg::REG_ANGLE_DEGREES: angle_cfg   = val[parp_pkg::ANGLE_WIDTH-1:0];
                parp_pkg::REG_PIVOT_X:       pivot_x_cfg = val[CW-1:0];
                parp_pkg::REG_PIVOT_Y:       pivot_y_cfg = val[CW-1:0];
                parp_pkg::REG_PIVOT_Z:       pivot_z_cfg = val[CW-1:0];
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic apply_setup(input logic [1:0] axis,
                               input logic signed [parp_pkg::ANGLE_WIDTH-1:0] angle,
                               input logic signed [CW-1:0] px,
                               input logic signed [CW-1:0] py,
                               input logic signed [CW-1:0] pz);
        begin
            set_reg(parp_pkg::REG_AXIS_SELECT, parp_pkg::CFG_DATA_WIDTH'(axis));
            set_reg(parp_pkg::REG_ANGLE_DEGREES, parp_pkg::CFG_DATA_WIDTH'(angle));
            set_reg(parp_pkg::REG_PIVOT_X, parp_pkg::CFG_DATA_WIDTH'(px));
            set_reg(parp_pkg::REG_PIVOT_Y, parp_pkg::CFG_DATA_WIDTH'(py));
            set_reg(parp_pkg::REG_PIVOT_Z, parp_pkg::CFG_DATA_WIDTH'(pz));
            @(posedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    task automatic queue_point(input logic signed [CW-1:0] x,
                               input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z);
        begin
            point_backlog.push_back('{x: x, y: y, z: z});
        end
    endtask

    // Hold until every beat is taken and every result is back, then let the pipe empty
    task automatic drain_pipeline();
        begin
            do
                @(posedge clk);
            while (point_backlog.size() != 0 || start || expected_points.size() != 0);
            repeat (parp_pkg::LATENCY + 4) @(posedge clk);
        end
    endtask

    // Driver: record each accepted beat, then present the next point or idle
    always @(posedge clk)
    begin : drive_proc
        point_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                expected_points.push_back(rotate_point(x_in, y_in, z_in));
                beats_taken++;
            end
            if (!(start && busy))
            begin
                if (point_backlog.size() != 0 &&
                    ((beats_taken >= 300 && beats_taken < 550) || $urandom_range(99) >= 17))
                begin
                    nxt = point_backlog.pop_front();
                    start <= 1'b1;
                    x_in  <= nxt.x;
                    y_in  <= nxt.y;
                    z_in  <= nxt.z;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat against the oldest expectation
    always @(posedge clk)
    begin : check_proc
        rotated_point_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_points.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: x=%0d y=%0d z=%0d sat=%0b",
                             x_out, y_out, z_out, saturated);
            end
            else
            begin
                want = expected_points.pop_front();
                if (x_out !== want.x || y_out !== want.y || z_out !== want.z ||
                    saturated !== want.sat)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b,",
                                 want.x, want.y, want.z, want.sat,
                                 " got x=%0d y=%0d z=%0d sat=%0b",
                                 x_out, y_out, z_out, saturated);
                end
            end
        end
    end

    initial
    begin
        logic [1:0]                              axis;
        logic signed [parp_pkg::ANGLE_WIDTH-1:0] angle;
        logic signed [CW-1:0]                    px, py, pz;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: z axis, zero angle, pivot at origin
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point('0, '0, '0);
        queue_point('1, 24'sd1, '1);
        drain_pipeline();

        // x axis at 45 degrees: the diagonal point overflows
        apply_setup(parp_pkg::AXIS_X, parp_pkg::ANGLE_WIDTH'(QUARTER_TURN / 2),
                    '0, '0, '0);
        queue_point('0, COORD_MAX, COORD_MAX);
        queue_point(COORD_MAX, COORD_MIN, 24'sd1);
        drain_pipeline();

        // y axis at 180 degrees with the pivot at the corners
        apply_setup(parp_pkg::AXIS_Y, parp_pkg::ANGLE_WIDTH'(HALF_TURN),
                    COORD_MAX, '0, COORD_MIN);
        queue_point(COORD_MIN, '0, COORD_MAX);
        queue_point(COORD_MAX, 24'sd5, COORD_MIN);
        drain_pipeline();

        // z axis just past a quarter turn, so the angle is folded
        apply_setup(parp_pkg::AXIS_Z, parp_pkg::ANGLE_WIDTH'(QUARTER_TURN + 1),
                    '0, COORD_MIN, '0);
        queue_point(24'sd1000, COORD_MIN, 24'sd7);
        queue_point(COORD_MIN, COORD_MAX, '0);
        drain_pipeline();

        // Angle register at its negative and positive ends, beyond a full turn
        apply_setup(parp_pkg::AXIS_Z, ANGLE_MOST_NEG, COORD_MIN, COORD_MAX, '0);
        queue_point(COORD_MAX, COORD_MIN, 24'sd3);
        queue_point(24'sd256, -24'sd256, COORD_MAX);
        drain_pipeline();
        apply_setup(parp_pkg::AXIS_X, ANGLE_MOST_POS, '0, COORD_MAX, COORD_MIN);
        queue_point(24'sd9, COORD_MIN, COORD_MAX);
        queue_point(COORD_MIN, 24'sd512, -24'sd512);
        drain_pipeline();

        // Unused axis code passes the point through
        apply_setup(parp_pkg::AXIS_NONE, parp_pkg::ANGLE_WIDTH'(30 * 256),
                    COORD_MAX, COORD_MIN, COORD_MAX);
        queue_point(COORD_MAX, COORD_MIN, COORD_MAX);
        queue_point(COORD_MIN, COORD_MAX, '0);
        drain_pipeline();

        // Negative quarter turn about y, and a negative half turn about z
        apply_setup(parp_pkg::AXIS_Y, parp_pkg::ANGLE_WIDTH'(-QUARTER_TURN),
                    24'sd256, -24'sd256, 24'sd512);
        queue_point('0, '0, '0);
        queue_point(COORD_MAX, '0, COORD_MIN);
        drain_pipeline();
        apply_setup(parp_pkg::AXIS_Z, parp_pkg::ANGLE_WIDTH'(-HALF_TURN), '0, '0, '0);
        queue_point(24'sd256, '0, '0);
        queue_point('0, COORD_MIN, COORD_MAX);
        drain_pipeline();

        // Random settings, a hundred random points under each
        for (int ph = 0; ph < 10; ph++)
        begin
            axis = ($urandom_range(9) == 0) ? parp_pkg::AXIS_NONE : 2'($urandom_range(2));
            case ($urandom_range(3))
                0: angle = parp_pkg::ANGLE_WIDTH'($urandom);
                1: angle = parp_pkg::ANGLE_WIDTH'(int'($urandom_range(0, 2 * FULL_TURN))
                                                  - FULL_TURN);
                2: angle = parp_pkg::ANGLE_WIDTH'((int'($urandom_range(0, 10)) - 5)
                                                  * QUARTER_TURN
                                                  + int'($urandom_range(0, 2)) - 1);
                default: angle = parp_pkg::ANGLE_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
            endcase
            px = pick_pivot();
            py = pick_pivot();
            pz = pick_pivot();
            apply_setup(axis, angle, px, py, pz);
            repeat (100)
                queue_point(pick_coord(px), pick_coord(py), pick_coord(pz));
            drain_pipeline();
        end

        if (fault_count == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/parp_pkg.sv
sv/parp_front.sv
sv/parp_cordic.sv
sv/parp_rotate.sv
sv/point_axis_rotation_about_pivot_unit.sv
tb/sv/tb.sv
